// ===== design/thkr_pkg.sv =====
package thkr_pkg;

	localparam int SLOT_W     = 10;
	localparam int MAP_W      = 50;
	localparam int CFG_IDX_W  = 3;
	localparam int WIN_W      = 16;
	localparam int NUM_MAP_REGS = 4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_TAP_WINDOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DTAP_WINDOW = 3'd1;
	localparam int                   CFG_MAP_BASE    = 2;

	localparam logic [WIN_W-1:0] TAP_WINDOW_RST  = 16'd200;
	localparam logic [WIN_W-1:0] DTAP_WINDOW_RST = 16'd150;

	// Event types, codes and key values.
	localparam logic [15:0] EV_SYN    = 16'd0;
	localparam logic [15:0] EV_KEY    = 16'd1;
	localparam logic [15:0] EV_MSC    = 16'd4;
	localparam logic [15:0] SCAN_CODE = 16'd4;
	localparam logic signed [31:0] KEY_RELEASE = 32'sd0;
	localparam logic signed [31:0] KEY_PRESS   = 32'sd1;

	// floor(x / 1000) == (x * USEC_RECIP) >> USEC_SHIFT for any 20-bit x.
	localparam logic [20:0] USEC_RECIP = 21'd1073742;
	localparam int          USEC_SHIFT = 30;

	typedef enum logic [2:0] {
		ST_RELEASED,
		ST_PRESSED,
		ST_TAPPED,
		ST_DOUBLE,
		ST_CONSUMED
	} map_state_t;

	typedef enum logic [1:0] {
		PLAN_FWD,
		PLAN_CHAIN,
		PLAN_TAP_RELEASE
	} plan_kind_t;

	typedef struct packed {
		plan_kind_t kind;
		logic       use_tap;
		logic       key_val;
	} plan_ctrl_t;

	typedef struct packed {
		logic [15:0]        ev_type;
		logic [15:0]        code;
		logic signed [31:0] value;
		logic [31:0]        sec;
		logic [19:0]        usec;
	} event_t;

endpackage

// ===== design/thkr_in_if.sv =====
interface thkr_in_if;
	logic               valid;
	logic               ready;
	logic [15:0]        in_type;
	logic [15:0]        in_code;
	logic signed [31:0] in_value;
	logic [31:0]        in_sec;
	logic [19:0]        in_usec;

	modport source (
		output valid, in_type, in_code, in_value, in_sec, in_usec,
		input  ready
	);
	modport sink (
		input  valid, in_type, in_code, in_value, in_sec, in_usec,
		output ready
	);
endinterface

// ===== design/thkr_out_if.sv =====
interface thkr_out_if;
	logic               valid;
	logic               ready;
	logic [15:0]        out_type;
	logic [15:0]        out_code;
	logic signed [31:0] out_value;
	logic [31:0]        out_sec;
	logic [19:0]        out_usec;
	logic               out_last;

	modport source (
		output valid, out_type, out_code, out_value, out_sec, out_usec, out_last,
		input  ready
	);
	modport sink (
		input  valid, out_type, out_code, out_value, out_sec, out_usec, out_last,
		output ready
	);
endinterface

// ===== design/tap_hold_key_remapper.sv =====
// Channel   Dir   Handshake      Payload
// evt_in    in    valid/ready    in_type, in_code, in_value, in_sec, in_usec
// evt_out   out   valid/ready    out_type .. out_usec, out_last (last event of a request)
// cfg       in    cfg_we         cfg_index, cfg_data (write only)
//
// A request is taken into an input register and decoded there; when it moves on, the key
// state and timestamps are updated and its event plan is loaded into the output sequencer.
// The sequencer emits one event per cycle while the output is not stalled; a request makes
// up to 6*CHAIN_LEN-1 events, eleven by default, and some requests make none.
// The first event passes from the input register through the sequencer to the output register.
// Reset puts every mapping in RELEASED with zero timestamps and restores the windows.
// A stalled output holds its register; the input keeps flowing until the sequencer is full.
module tap_hold_key_remapper #(
	parameter int NUM_MAPPINGS = 4,
	parameter int CHAIN_LEN    = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	thkr_in_if.sink                        evt_in,
	thkr_out_if.source                     evt_out,
	input  logic                           cfg_we,
	input  logic [thkr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [thkr_pkg::MAP_W-1:0]     cfg_data
);

	localparam int CW    = $clog2(CHAIN_LEN + 1);
	localparam int EXT_W = (2 * CHAIN_LEN + 1) * thkr_pkg::SLOT_W;

	logic [thkr_pkg::WIN_W-1:0] tap_win_q;
	logic [thkr_pkg::WIN_W-1:0] dtap_win_q;
	logic [thkr_pkg::MAP_W-1:0] map_q [NUM_MAPPINGS];

	thkr_pkg::map_state_t st_q    [NUM_MAPPINGS];
	logic [31:0]          csec_q  [NUM_MAPPINGS];
	logic [19:0]          cusec_q [NUM_MAPPINGS];

	logic                 valid_s1;
	thkr_pkg::event_t     ev_s1;

	logic                 is_scan;
	logic                 is_key;
	logic                 press;
	logic                 rel;
	logic [NUM_MAPPINGS-1:0] sel_oh;
	logic                 found;
	thkr_pkg::map_state_t st_sw [NUM_MAPPINGS];
	thkr_pkg::map_state_t cur_st;
	thkr_pkg::map_state_t new_st;
	logic [thkr_pkg::MAP_W-1:0] cur_word;
	logic [31:0]          cur_sec;
	logic [19:0]          cur_usec;
	logic                 upd;
	logic                 has_res;
	thkr_pkg::plan_ctrl_t ctrl;

	logic signed [32:0]   ds;
	logic signed [20:0]   du;
	logic [19:0]          du_mag;
	logic [40:0]          q_prod;
	logic [10:0]          q_mag;
	logic signed [11:0]   q;
	logic signed [43:0]   ds_w;
	logic signed [43:0]   elapsed;
	logic                 tap_hit;
	logic                 dtap_hit;

	logic [1:0][CHAIN_LEN-1:0][thkr_pkg::SLOT_W-1:0] comp;
	logic [1:0][CW-1:0]   cnt;
	logic [EXT_W-1:0]     ext;

	logic                 load_ready;
	logic                 s1_go;
	logic [NUM_MAPPINGS-1:0] pressed_vec;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_win_q  <= thkr_pkg::TAP_WINDOW_RST;
			dtap_win_q <= thkr_pkg::DTAP_WINDOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				thkr_pkg::CFG_TAP_WINDOW:  tap_win_q  <= cfg_data[thkr_pkg::WIN_W-1:0];
				thkr_pkg::CFG_DTAP_WINDOW: dtap_win_q <= cfg_data[thkr_pkg::WIN_W-1:0];
				default: ;
			endcase
		end
	end

	for (genvar i = 0; i < NUM_MAPPINGS; i++) begin : g_map
		if (i < thkr_pkg::NUM_MAP_REGS) begin : g_reg
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					map_q[i] <= '0;
				end else if (cfg_we &&
				             cfg_index == thkr_pkg::CFG_IDX_W'(thkr_pkg::CFG_MAP_BASE + i)) begin
					map_q[i] <= cfg_data;
				end
			end
		end else begin : g_none
			// Only the first mappings have a register; the rest stay unused.
			assign map_q[i] = '0;
		end
	end

	// Input register
	assign evt_in.ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt_in.ready) begin
			valid_s1 <= evt_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_in.valid && evt_in.ready) begin
			ev_s1.ev_type <= evt_in.in_type;
			ev_s1.code    <= evt_in.in_code;
			ev_s1.value   <= evt_in.in_value;
			ev_s1.sec     <= evt_in.in_sec;
			ev_s1.usec    <= evt_in.in_usec;
		end
	end

	assign is_scan = (ev_s1.ev_type == thkr_pkg::EV_MSC) && (ev_s1.code == thkr_pkg::SCAN_CODE);
	assign is_key  = (ev_s1.ev_type == thkr_pkg::EV_KEY);
	assign press   = (ev_s1.value == thkr_pkg::KEY_PRESS);
	assign rel     = (ev_s1.value == thkr_pkg::KEY_RELEASE);

	// Any key press turns a held mapping into a consumed one before the lookup.
	always_comb begin
		for (int i = 0; i < NUM_MAPPINGS; i++) begin
			st_sw[i] = (is_key && press && st_q[i] == thkr_pkg::ST_PRESSED) ?
			           thkr_pkg::ST_CONSUMED : st_q[i];
			pressed_vec[i] = (st_q[i] == thkr_pkg::ST_PRESSED);
		end
	end

	// First used mapping whose key matches wins.
	always_comb begin
		logic seen;
		logic hit;
		seen     = 1'b0;
		sel_oh   = '0;
		cur_st   = thkr_pkg::ST_RELEASED;
		cur_word = '0;
		cur_sec  = '0;
		cur_usec = '0;
		for (int i = 0; i < NUM_MAPPINGS; i++) begin
			hit = (map_q[i][thkr_pkg::SLOT_W-1:0] != '0) &&
			      (16'(map_q[i][thkr_pkg::SLOT_W-1:0]) == ev_s1.code);
			if (hit && !seen) begin
				sel_oh[i] = 1'b1;
				cur_st    = st_sw[i];
				cur_word  = map_q[i];
				cur_sec   = csec_q[i];
				cur_usec  = cusec_q[i];
			end
			seen = seen | hit;
		end
		found = seen;
	end

	// Elapsed milliseconds: seconds difference times 1000 plus the microsecond
	// difference divided by 1000, truncated toward zero.
	assign ds      = $signed({1'b0, ev_s1.sec}) - $signed({1'b0, cur_sec});
	assign du      = $signed({1'b0, ev_s1.usec}) - $signed({1'b0, cur_usec});
	assign du_mag  = du[20] ? 20'(-du) : du[19:0];
	assign q_prod  = 41'(du_mag) * 41'(thkr_pkg::USEC_RECIP);
	assign q_mag   = q_prod[thkr_pkg::USEC_SHIFT +: 11];
	assign q       = du[20] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
	assign ds_w    = {{11{ds[32]}}, ds};
	// 1000 = 1024 - 16 - 8
	assign elapsed = (ds_w <<< 10) - (ds_w <<< 4) - (ds_w <<< 3) + {{32{q[11]}}, q};
	assign tap_hit  = elapsed < $signed({28'b0, tap_win_q});
	assign dtap_hit = elapsed < $signed({28'b0, dtap_win_q});

	// Pack the nonzero codes of the tap chain (0) and the hold chain (1).
	assign ext = EXT_W'(cur_word);

	for (genvar g = 0; g < 2; g++) begin : g_comp
		localparam int BASE = (g == 0) ? 1 : 1 + CHAIN_LEN;
		always_comb begin
			logic [thkr_pkg::SLOT_W-1:0] c;
			comp[g] = '0;
			cnt[g]  = '0;
			for (int j = 0; j < CHAIN_LEN; j++) begin
				c = ext[(BASE + j) * thkr_pkg::SLOT_W +: thkr_pkg::SLOT_W];
				if (c != '0) begin
					for (int k = 0; k < CHAIN_LEN; k++) begin
						if (cnt[g] == CW'(k)) begin
							comp[g][k] = c;
						end
					end
					cnt[g] = cnt[g] + CW'(1);
				end
			end
		end
	end

	// Next state of the matched mapping and the plan of events.
	always_comb begin
		ctrl    = '{kind: thkr_pkg::PLAN_FWD, use_tap: 1'b0, key_val: 1'b0};
		has_res = 1'b0;
		upd     = 1'b0;
		new_st  = cur_st;
		if (is_scan) begin
			has_res = 1'b0;
		end else if (!is_key || !found) begin
			has_res = 1'b1;
		end else if (press) begin
			upd = 1'b1;
			if (cur_st inside {thkr_pkg::ST_TAPPED, thkr_pkg::ST_DOUBLE}) begin
				new_st = dtap_hit ? thkr_pkg::ST_DOUBLE : thkr_pkg::ST_PRESSED;
			end else begin
				new_st = thkr_pkg::ST_PRESSED;
			end
			ctrl.kind    = thkr_pkg::PLAN_CHAIN;
			ctrl.use_tap = (new_st == thkr_pkg::ST_DOUBLE);
			ctrl.key_val = 1'b1;
		end else if (rel) begin
			upd = 1'b1;
			case (cur_st)
				thkr_pkg::ST_PRESSED:
					new_st = tap_hit ? thkr_pkg::ST_TAPPED : thkr_pkg::ST_RELEASED;
				thkr_pkg::ST_CONSUMED:
					new_st = thkr_pkg::ST_RELEASED;
				default:
					new_st = cur_st;
			endcase
			if (new_st == thkr_pkg::ST_TAPPED) begin
				ctrl.kind = thkr_pkg::PLAN_TAP_RELEASE;
			end else begin
				ctrl.kind    = thkr_pkg::PLAN_CHAIN;
				ctrl.use_tap = (new_st == thkr_pkg::ST_DOUBLE);
			end
		end

		if (upd) begin
			if (ctrl.kind == thkr_pkg::PLAN_TAP_RELEASE) begin
				has_res = 1'b1;
			end else begin
				has_res = ctrl.use_tap ? (cnt[0] != '0) : (cnt[1] != '0);
			end
		end
	end

	assign s1_go = valid_s1 && (!has_res || load_ready);

	// Mapping state and timestamps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_MAPPINGS; i++) begin
				st_q[i]    <= thkr_pkg::ST_RELEASED;
				csec_q[i]  <= '0;
				cusec_q[i] <= '0;
			end
		end else if (s1_go && is_key) begin
			for (int i = 0; i < NUM_MAPPINGS; i++) begin
				st_q[i] <= st_sw[i];
				if (sel_oh[i] && upd) begin
					st_q[i]    <= new_st;
					csec_q[i]  <= ev_s1.sec;
					cusec_q[i] <= ev_s1.usec;
				end
			end
		end
	end

	thkr_seq #(
		.CHAIN_LEN (CHAIN_LEN)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1 && has_res),
		.load_ready (load_ready),
		.ctrl       (ctrl),
		.fwd        (ev_s1),
		.hold_codes (comp[1]),
		.hold_cnt   (cnt[1]),
		.tap_codes  (comp[0]),
		.tap_cnt    (cnt[0]),
		.evt_out    (evt_out)
	);

	// A press consumes every other held mapping, so at most one is ever held.
	a_one_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(pressed_vec) <= 1)
		else $error("more than one mapping in the pressed state");

	// Double tap is only reachable from a tapped or double-tapped mapping.
	a_double_from_tap: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && upd && new_st == thkr_pkg::ST_DOUBLE) |->
		(cur_st == thkr_pkg::ST_TAPPED || cur_st == thkr_pkg::ST_DOUBLE))
		else $error("double tap entered from a wrong state");

	// A request that cannot move on keeps its input register.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_go) |=> (valid_s1 && $stable(ev_s1)))
		else $error("input register lost a waiting request");

endmodule

// ===== design/thkr_seq.sv =====
module thkr_seq #(
	parameter int  CHAIN_LEN = 2,
	localparam int CW = $clog2(CHAIN_LEN + 1),
	localparam int LW = $clog2(2 * CHAIN_LEN),
	localparam int NW = $clog2(6 * CHAIN_LEN)
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     load_valid,
	output logic                                     load_ready,
	input  thkr_pkg::plan_ctrl_t                     ctrl,
	input  thkr_pkg::event_t                         fwd,
	input  logic [CHAIN_LEN-1:0][thkr_pkg::SLOT_W-1:0] hold_codes,
	input  logic [CW-1:0]                            hold_cnt,
	input  logic [CHAIN_LEN-1:0][thkr_pkg::SLOT_W-1:0] tap_codes,
	input  logic [CW-1:0]                            tap_cnt,
	thkr_out_if.source                               evt_out
);

	thkr_pkg::plan_ctrl_t                     ctrl_q;
	thkr_pkg::event_t                         fwd_q;
	logic [CHAIN_LEN-1:0][thkr_pkg::SLOT_W-1:0] hold_q;
	logic [CHAIN_LEN-1:0][thkr_pkg::SLOT_W-1:0] tap_q;
	logic [LW-1:0]                            lh_q;
	logic [LW-1:0]                            lt_q;
	logic [NW-1:0]                            total_q;
	logic [NW-1:0]                            k_q;
	logic                                     busy_q;

	logic                                     oval_q;
	thkr_pkg::event_t                         odata_q;
	logic                                     olast_q;

	logic [CW:0]        h2;
	logic [CW:0]        t2;
	logic [LW-1:0]      lh_d;
	logic [LW-1:0]      lt_d;
	logic [NW-1:0]      total_d;
	logic               advance;
	logic               last;
	thkr_pkg::event_t   cur;

	// A chain of m codes takes 2m-1 events: codes at even places, SYN reports between.
	assign h2   = {hold_cnt, 1'b0};
	assign t2   = {tap_cnt, 1'b0};
	assign lh_d = (hold_cnt == '0) ? '0 : LW'(h2 - 1'b1);
	assign lt_d = (tap_cnt == '0) ? '0 : LW'(t2 - 1'b1);

	always_comb begin
		case (ctrl.kind)
			thkr_pkg::PLAN_FWD:   total_d = NW'(1);
			thkr_pkg::PLAN_CHAIN: total_d = ctrl.use_tap ? NW'(lt_d) : NW'(lh_d);
			thkr_pkg::PLAN_TAP_RELEASE: total_d = NW'(lh_d) + NW'(lt_d) + NW'(lt_d) + NW'(2);
			default:              total_d = NW'(1);
		endcase
	end

	assign last       = (k_q == total_q - 1'b1);
	assign advance    = busy_q && (!oval_q || evt_out.ready);
	assign load_ready = !busy_q || (advance && last);

	// Decode the event at place k_q of the current plan.
	always_comb begin
		logic [NW-1:0]              p;
		logic [NW-1:0]              b1;
		logic [NW-1:0]              b2;
		logic                       in_chain;
		logic                       from_tap;
		logic                       v;
		logic [thkr_pkg::SLOT_W-1:0] c;

		p        = k_q;
		b1       = NW'(lh_q);
		b2       = NW'(lh_q) + NW'(lt_q) + NW'(1);
		in_chain = 1'b0;
		from_tap = ctrl_q.use_tap;
		v        = ctrl_q.key_val;
		c        = '0;
		cur      = '0;

		case (ctrl_q.kind)
			thkr_pkg::PLAN_FWD: begin
				cur = fwd_q;
			end
			thkr_pkg::PLAN_CHAIN: begin
				in_chain = 1'b1;
			end
			thkr_pkg::PLAN_TAP_RELEASE: begin
				// Hold release, SYN, tap press, SYN, tap release.
				if (k_q < b1) begin
					in_chain = 1'b1;
					from_tap = 1'b0;
					v        = 1'b0;
				end else if (k_q == b1) begin
					in_chain = 1'b0;
				end else if (k_q < b2) begin
					in_chain = 1'b1;
					from_tap = 1'b1;
					v        = 1'b1;
					p        = k_q - b1 - NW'(1);
				end else if (k_q == b2) begin
					in_chain = 1'b0;
				end else begin
					in_chain = 1'b1;
					from_tap = 1'b1;
					v        = 1'b0;
					p        = k_q - b2 - NW'(1);
				end
			end
			default: begin
				cur = fwd_q;
			end
		endcase

		for (int j = 0; j < CHAIN_LEN; j++) begin
			if (p[NW-1:1] == (NW-1)'(j)) begin
				c = from_tap ? tap_q[j] : hold_q[j];
			end
		end

		if (ctrl_q.kind != thkr_pkg::PLAN_FWD) begin
			if (in_chain && !p[0]) begin
				cur.ev_type = thkr_pkg::EV_KEY;
				cur.code    = 16'(c);
				cur.value   = $signed(32'(v));
			end else begin
				cur.ev_type = thkr_pkg::EV_SYN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (load_valid && load_ready) begin
			busy_q <= 1'b1;
			k_q    <= '0;
		end else if (advance) begin
			k_q <= k_q + NW'(1);
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			ctrl_q  <= ctrl;
			fwd_q   <= fwd;
			hold_q  <= hold_codes;
			tap_q   <= tap_codes;
			lh_q    <= lh_d;
			lt_q    <= lt_d;
			total_q <= total_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
		end else if (!oval_q || evt_out.ready) begin
			oval_q <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			odata_q <= cur;
			olast_q <= last;
		end
	end

	assign evt_out.valid     = oval_q;
	assign evt_out.out_type  = odata_q.ev_type;
	assign evt_out.out_code  = odata_q.code;
	assign evt_out.out_value = odata_q.value;
	assign evt_out.out_sec   = odata_q.sec;
	assign evt_out.out_usec  = odata_q.usec;
	assign evt_out.out_last  = olast_q;

endmodule
